// File: hdl/flc_pkg.sv
// Shared types, field widths and the base-6 digit helper for the stencil candidate block.
package flc_pkg;

   localparam int CODE_W  = 30;
   localparam int INDEX_W = 8;
   localparam int LEVEL_W = 4;
   localparam int KIND_W  = 2;
   localparam int DIGIT_W = 3;
   localparam int STENCIL_DIGITS = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd10;

   typedef enum logic [KIND_W-1:0] {
      KIND_OUTSIDE     = 2'd0,
      KIND_SELF        = 2'd1,
      KIND_NEAR        = 2'd2,
      KIND_INTERACTION = 2'd3
   } kind_type;

   typedef struct packed {
      logic [5:0]         quo;
      logic [DIGIT_W-1:0] rem;
   } div6_type;

   // 8-bit value / 6 by reciprocal: (v * 171) >> 10 is exact for v < 256
   function automatic div6_type div6(input logic [INDEX_W-1:0] v);
      logic [15:0]        prod;
      logic [5:0]         q;
      logic [INDEX_W-1:0] back;
      div6_type           res;
      prod     = {8'd0, v} * 16'd171;
      q        = prod[15:10];
      back     = v - INDEX_W'({2'd0, q} * 8'd6);
      res.quo  = q;
      res.rem  = back[DIGIT_W-1:0];
      return res;
   endfunction

endpackage

// File: hdl/flc_if.sv
// Valid/ready channel interfaces for request and response words.
interface flc_req_if
   import flc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   cell_code;
   logic [INDEX_W-1:0]  offset_index;

   modport source (output valid, output cell_code, output offset_index, input ready);
   modport sink   (input valid, input cell_code, input offset_index, output ready);
endinterface

interface flc_rsp_if
   import flc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   candidate_code;
   kind_type            kind;

   modport source (output valid, output candidate_code, output kind, input ready);
   modport sink   (input valid, input candidate_code, input kind, output ready);
endinterface

// File: hdl/fmm_interaction_list_candidate.sv
// Top level: FMM interaction stencil candidate id and class per request word.
// A request word passes the input register, then the result register, before
// response valid; throughput one word per cycle unless the response side stalls,
// set by the single combinational pass between the two registers.
// Reset (synchronous, active high) clears both stage valids and sets
// tree_level to 10.
module fmm_interaction_list_candidate
   import flc_pkg::*;
#(
   parameter int DIMS      = 3,
   parameter int MAX_LEVEL = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [LEVEL_W-1:0] csr_write_data,
   flc_req_if.sink            req_word,
   flc_rsp_if.source          rsp_word
);

   // candidate coordinate width: sign, carry, and room for offsets of +-3
   localparam int CW = MAX_LEVEL + 3;

   logic [LEVEL_W-1:0]  level_ff, level_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [CODE_W-1:0]   s1_code_ff;
   logic [INDEX_W-1:0]  s1_index_ff;

   logic                s2_valid_ff, s2_valid_in;
   logic [CODE_W-1:0]   s2_code_ff, s2_code_in;
   kind_type            s2_kind_ff, s2_kind_in;

   logic                s2_load;
   logic                s1_load;

   logic [LEVEL_W-1:0]          level_eff;
   div6_type                    dv0, dv1, dv2;
   logic [DIGIT_W-1:0]          digit [STENCIL_DIGITS];
   logic [MAX_LEVEL-1:0]        coord [DIMS];
   logic signed [3:0]           off   [DIMS];
   logic signed [CW-1:0]        cand  [DIMS];
   logic                        outside, near, self_hit;
   logic [CODE_W-1:0]           code_c;

   assign s2_load = !s2_valid_ff || rsp_word.ready;
   assign s1_load = !s1_valid_ff || s2_load;

   assign req_word.ready = s1_load;

   assign level_in    = csr_write_en ? csr_write_data : level_ff;
   assign s1_valid_in = s1_load ? req_word.valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      level_eff = (level_ff > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : level_ff;

      dv0 = div6(s1_index_ff);
      dv1 = div6({2'd0, dv0.quo});
      dv2 = div6({2'd0, dv1.quo});
      digit[0] = dv0.rem;
      digit[1] = dv1.rem;
      digit[2] = dv2.rem;

      outside  = 1'b0;
      near     = 1'b1;
      self_hit = 1'b1;
      code_c   = '0;

      for (int d = 0; d < DIMS; d++) begin
         for (int b = 0; b < MAX_LEVEL; b++) begin
            coord[d][b] = s1_code_ff[b*DIMS + d];
         end
         // offset spans -2..3 for even coordinate, -3..2 for odd
         off[d]  = $signed({1'b0, digit[d]}) - 4'sd2 - $signed({3'b000, coord[d][0]});
         cand[d] = $signed({3'b000, coord[d]}) + CW'(off[d]);
         if (off[d] < -4'sd1 || off[d] > 4'sd1) begin
            near = 1'b0;
         end
         if (off[d] != 4'sd0) begin
            self_hit = 1'b0;
         end
         if (cand[d][CW-1] || ((cand[d][CW-2:0] >> level_eff) != '0)) begin
            outside = 1'b1;
         end
         for (int b = 0; b < MAX_LEVEL; b++) begin
            code_c[b*DIMS + d] = cand[d][b];
         end
      end

      if (outside) begin
         s2_code_in = '0;
         s2_kind_in = KIND_OUTSIDE;
      end else begin
         s2_code_in = code_c;
         if (self_hit) begin
            s2_kind_in = KIND_SELF;
         end else if (near) begin
            s2_kind_in = KIND_NEAR;
         end else begin
            s2_kind_in = KIND_INTERACTION;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= LEVEL_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         level_ff    <= level_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_code_ff  <= req_word.cell_code;
         s1_index_ff <= req_word.offset_index;
      end
      if (s2_load) begin
         s2_code_ff <= s2_code_in;
         s2_kind_ff <= s2_kind_in;
      end
   end

   assign rsp_word.valid          = s2_valid_ff;
   assign rsp_word.candidate_code = s2_code_ff;
   assign rsp_word.kind           = s2_kind_ff;

endmodule

// File: tb/sv/flc_candidate_monitor.sv
// Response predictor and compare for the stencil candidate block.
`timescale 1ns / 1ps

module flc_candidate_monitor
   import flc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [LEVEL_W-1:0] csr_write_data,
   flc_req_if                 req,
   flc_rsp_if                 rsp,
   output int                 pending,
   output int                 mismatches,
   output int                 results_checked
);

   localparam int AXES      = 3;
   localparam int LEVEL_TOP = 10;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      kind_type          kind;
   } candidate_type;

   logic [LEVEL_W-1:0] level_q;
   candidate_type      candidates_q[$];

   // De-interleave, apply the per-axis stencil shift, re-interleave.
   function automatic candidate_type predict_candidate(input logic [LEVEL_W-1:0] level,
                                                       input logic [CODE_W-1:0]  cell_word,
                                                       input logic [INDEX_W-1:0] index);
      int unsigned eff_level;
      int unsigned span;
      int unsigned digits;
      int          coord[AXES];
      int          shift[AXES];
      bit          outside;
      bit          near;
      bit          self_hit;
      logic [CODE_W-1:0] code;
      candidate_type res;
      eff_level = (level > LEVEL_TOP) ? LEVEL_TOP : level;
      span      = 1 << eff_level;
      digits    = index;
      outside   = 1'b0;
      near      = 1'b1;
      self_hit  = 1'b1;
      code      = '0;
      for (int d = 0; d < AXES; d++) begin
         coord[d] = 0;
         for (int b = 0; b < LEVEL_TOP; b++)
            coord[d][b] = cell_word[b*AXES + d];
         // even coordinate: -2..3, odd: -3..2
         shift[d] = int'(digits % 6) - 2 - (coord[d] & 1);
         digits   = digits / 6;
         if (shift[d] < -1 || shift[d] > 1)
            near = 1'b0;
         if (shift[d] != 0)
            self_hit = 1'b0;
         coord[d] += shift[d];
         if (coord[d] < 0 || coord[d] >= int'(span))
            outside = 1'b1;
      end
      if (!outside) begin
         for (int d = 0; d < AXES; d++)
            for (int b = 0; b < LEVEL_TOP; b++)
               code[b*AXES + d] = coord[d][b];
      end
      res.code = code;
      if (outside)
         res.kind = KIND_OUTSIDE;
      else if (self_hit)
         res.kind = KIND_SELF;
      else if (near)
         res.kind = KIND_NEAR;
      else
         res.kind = KIND_INTERACTION;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      candidate_type want;
      if (reset) begin
         level_q <= LEVEL_RESET;
         candidates_q.delete();
         pending <= 0;
      end else begin
         if (csr_write_en)
            level_q <= csr_write_data;
         if (req.valid && req.ready)
            candidates_q = {candidates_q, predict_candidate(level_q, req.cell_code,
                                                            req.offset_index)};
         if (rsp.valid && rsp.ready) begin
            if (candidates_q.size() == 0) begin
               $display("%0t: unexpected response word: code %h kind %0d", $time,
                        rsp.candidate_code, rsp.kind);
               mismatches++;
            end else begin
               want = candidates_q.pop_front();
               results_checked++;
               if (rsp.candidate_code !== want.code) begin
                  $display("%0t: candidate_code mismatch: expected %h, actual %h", $time,
                           want.code, rsp.candidate_code);
                  mismatches++;
               end
               if (rsp.kind !== want.kind) begin
                  $display("%0t: kind mismatch: expected %0d, actual %0d", $time,
                           want.kind, rsp.kind);
                  mismatches++;
               end
            end
         end
         // registered so the stimulus side reads a settled count
         pending <= candidates_q.size();
      end
   end

endmodule

// File: tb/sv/fmm_interaction_list_candidate_tb.sv
// Stimulus, reset, watchdog and verdict for the stencil candidate block.
`timescale 1ns / 1ps

module fmm_interaction_list_candidate_tb;
   import flc_pkg::*;

   localparam int STALL_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_WORDS    = 140;
   localparam int N_PHASES       = 12;
   localparam int N_DIRECTED     = 20;

   localparam logic [LEVEL_W-1:0] LEVEL_PLAN [N_PHASES] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd15, 4'd4, 4'd6, 4'd8, 4'd9, 4'd5, 4'd7, 4'd10};

   // All-even cell, all-odd cell (1023) and all-1022 cell against
   // the stencil corners, self, near, per-axis underflow and overflow,
   // and indexes past the 216-entry stencil.
   localparam logic [CODE_W-1:0] DIR_CODE [N_DIRECTED] = '{
      30'h00000000, 30'h00000000, 30'h00000000, 30'h00000000, 30'h00000000,
      30'h00000000, 30'h00000000, 30'h00000000, 30'h00000000, 30'h3FFFFFFF,
      30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFFF, 30'h3FFFFFF8,
      30'h3FFFFFF8, 30'h3FFFFFF8, 30'h2AAAAAAA, 30'h15555555, 30'h24924924};
   localparam logic [INDEX_W-1:0] DIR_INDEX [N_DIRECTED] = '{
      8'd0,   8'd86,  8'd129, 8'd215, 8'd255,
      8'd216, 8'd84,  8'd74,  8'd14,  8'd129,
      8'd86,  8'd215, 8'd0,   8'd255, 8'd215,
      8'd172, 8'd129, 8'd43,  8'd170, 8'd200};

   logic clock = 1'b0;
   logic reset;
   logic               csr_write_en;
   logic [LEVEL_W-1:0] csr_write_data;

   flc_req_if req_word ();
   flc_rsp_if rsp_word ();

   int pending;
   int mismatches;
   int results_checked;
   int idle_pct;
   int words_sent;
   int idle_cycles;
   // long response hold: requested by stimulus, acknowledged by the drain side
   int hold_req;
   int hold_done;

   fmm_interaction_list_candidate dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_word       (req_word),
      .rsp_word       (rsp_word)
   );

   flc_candidate_monitor candidate_mon (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req             (req_word),
      .rsp             (rsp_word),
      .pending         (pending),
      .mismatches      (mismatches),
      .results_checked (results_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_word.valid && req_word.ready) || (rsp_word.valid && rsp_word.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d words still due", $time, pending);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Response side: random stall bursts, plus one long hold when asked.
   initial begin : rsp_drain
      int gap;
      rsp_word.ready <= 1'b0;
      forever begin
         if (hold_req != hold_done) begin
            rsp_word.ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            hold_done++;
         end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 7);
            rsp_word.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_word.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Leaves valid high on return; the caller lowers it when it stops sending.
   task automatic send_word(input logic [CODE_W-1:0] code, input logic [INDEX_W-1:0] index);
      int gap;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 7);
         req_word.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word.valid        <= 1'b1;
      req_word.cell_code    <= code;
      req_word.offset_index <= index;
      do @(posedge clock); while (!req_word.ready);
      words_sent++;
   endtask

   task automatic drain_words();
      req_word.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : stimulus
      int unsigned       eff_level;
      int unsigned       pick;
      logic [CODE_W-1:0] mask;
      logic [CODE_W-1:0] code;
      logic [INDEX_W-1:0] index;
      idle_pct    = 0;
      words_sent  = 0;
      reset                 <= 1'b1;
      csr_write_en          <= 1'b0;
      csr_write_data        <= '0;
      req_word.valid        <= 1'b0;
      req_word.cell_code    <= '0;
      req_word.offset_index <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset level
      for (int i = 0; i < N_DIRECTED; i++)
         send_word(DIR_CODE[i], DIR_INDEX[i]);

      for (int p = 0; p < N_PHASES; p++) begin
         drain_words();
         repeat (3) @(posedge clock);
         csr_write_en   <= 1'b1;
         csr_write_data <= LEVEL_PLAN[p];
         @(posedge clock);
         csr_write_en   <= 1'b0;
         idle_pct  = (p == N_PHASES - 1 || p % 4 == 2) ? 0 : 25;
         eff_level = (LEVEL_PLAN[p] > 10) ? 10 : LEVEL_PLAN[p];
         mask      = CODE_W'((64'd1 << (3 * eff_level)) - 64'd1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 3 && n == 50)
               hold_req++;
            if (p == 5 && n == 70)
               drain_words();
            pick = $urandom_range(99);
            if (pick < 70) begin
               // cell inside the level, stencil index in range
               code  = CODE_W'($urandom) & mask;
               index = INDEX_W'($urandom_range(0, 215));
            end else if (pick < 82) begin
               // each axis at zero or at the level's top, parity varied
               code  = (mask & {10{3'($urandom)}}) ^ (CODE_W'($urandom_range(0, 7)) & mask);
               index = INDEX_W'($urandom_range(0, 215));
            end else begin
               code  = CODE_W'($urandom);
               index = INDEX_W'($urandom_range(0, 255));
            end
            send_word(code, index);
         end
      end

      drain_words();
      repeat (4) @(posedge clock);
      $display("Run covered %0d request words, %0d responses checked, over tree_level", words_sent,
               results_checked);
      $display("0..15 with a long response stall, a drain pause and idle-free stretches.");
      if (mismatches == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/flc_pkg.sv
hdl/flc_if.sv
hdl/fmm_interaction_list_candidate.sv
tb/sv/flc_candidate_monitor.sv
tb/sv/fmm_interaction_list_candidate_tb.sv
